// ===== src/pcr_pkg.sv =====
// Shared constants, types and controller/datapath interface structs for the
// palette color registry. No dependencies.
package pcr_pkg;

    localparam int TABLE_DEPTH   = 256;
    localparam int RESERVED_BASE = 208;

    localparam int COLOR_W = 16;
    localparam int ADDR_W  = $clog2(TABLE_DEPTH);
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] BASE_CNT  = CNT_W'(RESERVED_BASE);

    typedef enum logic [1:0] {
        OP_REGISTER = 2'd0,
        OP_FIND     = 2'd1,
        OP_REPLACE  = 2'd2,
        OP_READ     = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_APPEND,
        RES_HIT,
        RES_REPLACE,
        RES_READ
    } res_kind_t;

    // controller -> datapath
    typedef struct packed {
        logic      load;
        logic      scan_start;
        logic      scan_run;
        logic      rd_index;
        logic      wr_append;
        logic      wr_index;
        logic      finish;
        res_kind_t res_kind;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        op_t  op;
        logic full;
        logic idx_in;
        logic rep_ok;
        logic idx_at_base;
        logic hit;
        logic miss;
    } sts_t;

endpackage

// ===== src/pcr_ctrl.sv =====
// Sequencing controller for the palette color registry.
// Depends on pcr_pkg (op_t, cmd_t, sts_t).
module pcr_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  pcr_pkg::sts_t sts,
    output logic          busy,
    output pcr_pkg::cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_READ_WAIT
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_kind = pcr_pkg::RES_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                case (sts.op)
                    pcr_pkg::OP_REGISTER:
                    begin
                        if (sts.full)
                        begin
                            cmd.finish = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                    end
                    pcr_pkg::OP_FIND:
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_SCAN;
                    end
                    pcr_pkg::OP_REPLACE:
                    begin
                        if (!sts.rep_ok)
                        begin
                            cmd.finish = 1'b1;
                            state_next = S_IDLE;
                        end
                        else if (sts.idx_at_base)
                        begin
                            // base slot takes duplicates, no scan needed
                            cmd.wr_index = 1'b1;
                            cmd.finish   = 1'b1;
                            cmd.res_kind = pcr_pkg::RES_REPLACE;
                            state_next   = S_IDLE;
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                    end
                    default:
                    begin
                        if (sts.idx_in)
                        begin
                            cmd.rd_index = 1'b1;
                            state_next   = S_READ_WAIT;
                        end
                        else
                        begin
                            cmd.finish = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end
            S_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (sts.hit)
                begin
                    cmd.finish = 1'b1;
                    if (sts.op == pcr_pkg::OP_FIND)
                        cmd.res_kind = pcr_pkg::RES_HIT;
                    state_next = S_IDLE;
                end
                else if (sts.miss)
                begin
                    cmd.finish = 1'b1;
                    case (sts.op)
                        pcr_pkg::OP_REGISTER:
                        begin
                            cmd.wr_append = 1'b1;
                            cmd.res_kind  = pcr_pkg::RES_APPEND;
                        end
                        pcr_pkg::OP_REPLACE:
                        begin
                            cmd.wr_index = 1'b1;
                            cmd.res_kind = pcr_pkg::RES_REPLACE;
                        end
                        default:
                        begin
                            cmd.res_kind = pcr_pkg::RES_NONE;
                        end
                    endcase
                    state_next = S_IDLE;
                end
            end
            S_READ_WAIT:
            begin
                cmd.finish   = 1'b1;
                cmd.res_kind = pcr_pkg::RES_READ;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        busy_next = (state_next != S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy = busy_reg;

endmodule

// ===== src/pcr_dpath.sv =====
// Datapath of the palette color registry: palette memory, fill count, scan
// pointer with compare stage, and result registers. Depends on pcr_pkg.
module pcr_dpath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pcr_pkg::cmd_t                 cmd,
    input  logic [1:0]                    func,
    input  logic [pcr_pkg::COLOR_W-1:0]   color,
    input  logic [pcr_pkg::ADDR_W-1:0]    index,
    output pcr_pkg::sts_t                 sts,
    output logic                          done,
    output logic [pcr_pkg::ADDR_W-1:0]    result_index,
    output logic                          found,
    output logic [pcr_pkg::COLOR_W-1:0]   color_out,
    output logic                          accepted,
    output logic [pcr_pkg::CNT_W-1:0]     entry_count
);

    logic [pcr_pkg::COLOR_W-1:0] mem [pcr_pkg::TABLE_DEPTH];

    pcr_pkg::op_t                op_reg;
    logic [pcr_pkg::COLOR_W-1:0] color_reg;
    logic [pcr_pkg::ADDR_W-1:0]  idx_reg;

    logic [pcr_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [pcr_pkg::CNT_W-1:0]   ptr_reg, ptr_next;
    logic                        rd_vld_reg, rd_vld_next;
    logic [pcr_pkg::ADDR_W-1:0]  cmp_idx_reg;
    logic [pcr_pkg::COLOR_W-1:0] rd_data_reg;
    logic [pcr_pkg::ADDR_W-1:0]  rd_addr;
    logic                        issue;

    logic                        done_reg;
    logic [pcr_pkg::ADDR_W-1:0]  result_index_reg, result_index_next;
    logic                        found_reg, accepted_reg;
    logic [pcr_pkg::COLOR_W-1:0] color_out_reg, color_out_next;
    logic [pcr_pkg::CNT_W-1:0]   entry_count_reg, entry_count_next;

    logic [pcr_pkg::CNT_W-1:0]   idx_ext;

    assign idx_ext = {{(pcr_pkg::CNT_W - pcr_pkg::ADDR_W){1'b0}}, idx_reg};

    // status
    always_comb
    begin
        sts.op          = op_reg;
        sts.full        = (count_reg == pcr_pkg::DEPTH_CNT);
        sts.idx_in      = (idx_ext < count_reg);
        sts.rep_ok      = sts.idx_in && (idx_ext >= pcr_pkg::BASE_CNT);
        sts.idx_at_base = (idx_ext == pcr_pkg::BASE_CNT);
        sts.hit         = rd_vld_reg && (rd_data_reg == color_reg);
        sts.miss        = !rd_vld_reg && (ptr_reg == count_reg);
    end

    // scan pointer: one read issued per cycle, compared in the next cycle from the registered read data
    assign issue   = cmd.scan_run && (ptr_reg < count_reg);
    assign rd_addr = cmd.rd_index ? idx_reg : ptr_reg[pcr_pkg::ADDR_W-1:0];

    always_comb
    begin
        ptr_next    = ptr_reg;
        rd_vld_next = rd_vld_reg;
        count_next  = count_reg;
        if (cmd.scan_start)
        begin
            ptr_next    = '0;
            rd_vld_next = 1'b0;
        end
        else if (cmd.scan_run)
        begin
            rd_vld_next = issue;
            if (issue)
                ptr_next = ptr_reg + 1'b1;
        end
        if (cmd.wr_append)
            count_next = count_reg + 1'b1;
    end

    // result word
    always_comb
    begin
        result_index_next = '0;
        color_out_next    = '0;
        entry_count_next  = count_next;
        case (cmd.res_kind)
            pcr_pkg::RES_APPEND: result_index_next = count_reg[pcr_pkg::ADDR_W-1:0];
            pcr_pkg::RES_HIT:    result_index_next = cmp_idx_reg;
            pcr_pkg::RES_READ:   color_out_next    = rd_data_reg;
            default:             result_index_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            ptr_reg         <= '0;
            rd_vld_reg      <= 1'b0;
            done_reg        <= 1'b0;
            entry_count_reg <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            ptr_reg    <= ptr_next;
            rd_vld_reg <= rd_vld_next;
            done_reg   <= cmd.finish;
            if (cmd.finish)
                entry_count_reg <= entry_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= pcr_pkg::op_t'(func);
            color_reg <= color;
            idx_reg   <= index;
        end
        if (issue)
            cmp_idx_reg <= ptr_reg[pcr_pkg::ADDR_W-1:0];
        if (cmd.finish)
        begin
            result_index_reg <= result_index_next;
            found_reg        <= (cmd.res_kind == pcr_pkg::RES_HIT);
            color_out_reg    <= color_out_next;
            accepted_reg     <= (cmd.res_kind == pcr_pkg::RES_APPEND) ||
                                (cmd.res_kind == pcr_pkg::RES_REPLACE);
        end
    end

    // palette memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_append)
            mem[count_reg[pcr_pkg::ADDR_W-1:0]] <= color_reg;
        else if (cmd.wr_index)
            mem[idx_reg] <= color_reg;
        rd_data_reg <= mem[rd_addr];
    end

    assign done         = done_reg;
    assign result_index = result_index_reg;
    assign found        = found_reg;
    assign color_out    = color_out_reg;
    assign accepted     = accepted_reg;
    assign entry_count  = entry_count_reg;

endmodule

// ===== src/palette_color_registry.sv =====
// Palette color registry top level: controller plus datapath.
// Depends on pcr_pkg, pcr_ctrl and pcr_dpath.
//
// A command word is taken when start is high and busy is low; exactly one
// result word follows, shown for one cycle with done high, and the receiver
// cannot hold it off. Register, find and replace above the base slot scan
// the filled entries (the fill count is at most 256) through the single read
// port of the palette memory, one entry per cycle, and a match ends the scan
// early. A read below the count waits for the registered memory read; a read
// beyond the count, a command refused before any scan or a replace at the
// base slot finishes without one.
// done is high in the first cycle with busy low, and the next command may be
// started in that same cycle. The palette memory is not cleared; the fill
// count resets to 0.
module palette_color_registry (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    func,
    input  logic [pcr_pkg::COLOR_W-1:0]   color,
    input  logic [pcr_pkg::ADDR_W-1:0]    index,
    output logic                          done,
    output logic [pcr_pkg::ADDR_W-1:0]    result_index,
    output logic                          found,
    output logic [pcr_pkg::COLOR_W-1:0]   color_out,
    output logic                          accepted,
    output logic [pcr_pkg::CNT_W-1:0]     entry_count
);

    pcr_pkg::cmd_t cmd;
    pcr_pkg::sts_t sts;
    logic          start_ok;

    assign start_ok = start && !busy;

    pcr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_ok),
        .sts   (sts),
        .busy  (busy),
        .cmd   (cmd)
    );

    pcr_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .func         (func),
        .color        (color),
        .index        (index),
        .sts          (sts),
        .done         (done),
        .result_index (result_index),
        .found        (found),
        .color_out    (color_out),
        .accepted     (accepted),
        .entry_count  (entry_count)
    );

endmodule

// ===== src/pcr_checker.sv =====
// Port-level checker for the palette color registry, bound to the top level.
// Depends on pcr_pkg for widths.
module pcr_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          done,
    input logic                          found,
    input logic                          accepted,
    input logic [pcr_pkg::COLOR_W-1:0]   color_out,
    input logic [pcr_pkg::CNT_W-1:0]     entry_count
);

    // a taken command always raises busy in the following cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy did not rise after a command was taken");

    // a result word only follows a busy cycle
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> !done)
        else $error("done without a command in flight");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("busy still high with the result word");

    // the count only moves on a write that was taken
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        done && !accepted |-> $stable(entry_count))
        else $error("fill count changed on a refused command");

    a_find_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && found |-> !accepted && (color_out == '0))
        else $error("find result carries write or read fields");

endmodule

bind palette_color_registry pcr_checker u_pcr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .found       (found),
    .accepted    (accepted),
    .color_out   (color_out),
    .entry_count (entry_count)
);

// ===== dv/tb_palette_color_registry.sv =====
// Self-checking testbench for palette_color_registry: directed and random command words,
// with a predictor built into the bench and a check of every result word.
// Depends on pcr_pkg and the palette_color_registry RTL.
module tb_palette_color_registry;

    localparam int RANDOM_ITEMS = 1930;
    localparam int PHASE_ITEMS  = 650;
    localparam int DRAIN_CYCLES = 300;

    typedef struct packed {
        pcr_pkg::op_t                op;
        logic [pcr_pkg::COLOR_W-1:0] color;
        logic [pcr_pkg::ADDR_W-1:0]  slot;
    } palette_cmd_t;

    typedef struct packed {
        logic [pcr_pkg::ADDR_W-1:0]  slot;
        logic                        hit;
        logic [pcr_pkg::COLOR_W-1:0] shade;
        logic                        wrote;
        logic [pcr_pkg::CNT_W-1:0]   count;
    } palette_result_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        start = 1'b0;
    logic [1:0]                  func = '0;
    logic [pcr_pkg::COLOR_W-1:0] color = '0;
    logic [pcr_pkg::ADDR_W-1:0]  index = '0;
    logic                        busy;
    logic                        done;
    logic [pcr_pkg::ADDR_W-1:0]  result_index;
    logic                        found;
    logic [pcr_pkg::COLOR_W-1:0] color_out;
    logic                        accepted;
    logic [pcr_pkg::CNT_W-1:0]   entry_count;

    // bench copy of the palette contents and fill count
    logic [pcr_pkg::COLOR_W-1:0] palette_mem [pcr_pkg::TABLE_DEPTH];
    int unsigned                 palette_fill = 0;

    palette_cmd_t    command_backlog [$];
    palette_result_t expected_results [$];
    int unsigned     issued_count = 0;
    int unsigned     mismatch_count = 0;

    palette_color_registry i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .color        (color),
        .index        (index),
        .done         (done),
        .result_index (result_index),
        .found        (found),
        .color_out    (color_out),
        .accepted     (accepted),
        .entry_count  (entry_count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // first filled slot holding c, or -1
    function automatic int scan_palette(logic [pcr_pkg::COLOR_W-1:0] c);
        for (int j = 0; j < palette_fill; j++)
        begin
            if (palette_mem[pcr_pkg::ADDR_W'(j)] == c)
                return j;
        end
        return -1;
    endfunction

    function automatic palette_result_t palette_apply(palette_cmd_t cmd);
        palette_result_t res;
        int              hit_slot;
        res = '0;
        hit_slot = scan_palette(cmd.color);
        case (cmd.op)
            pcr_pkg::OP_REGISTER:
            begin
                if (palette_fill < pcr_pkg::TABLE_DEPTH && hit_slot < 0)
                begin
                    res.slot = pcr_pkg::ADDR_W'(palette_fill);
                    palette_mem[pcr_pkg::ADDR_W'(palette_fill)] = cmd.color;
                    palette_fill++;
                    res.wrote = 1'b1;
                end
            end
            pcr_pkg::OP_FIND:
            begin
                if (hit_slot >= 0)
                begin
                    res.slot = pcr_pkg::ADDR_W'(hit_slot);
                    res.hit = 1'b1;
                end
            end
            pcr_pkg::OP_REPLACE:
            begin
                // the base slot takes duplicates, slots above it do not
                if (cmd.slot < palette_fill && cmd.slot >= pcr_pkg::RESERVED_BASE &&
                    (cmd.slot == pcr_pkg::RESERVED_BASE || hit_slot < 0))
                begin
                    palette_mem[cmd.slot] = cmd.color;
                    res.wrote = 1'b1;
                end
            end
            default:
            begin
                if (cmd.slot < palette_fill)
                    res.shade = palette_mem[cmd.slot];
            end
        endcase
        res.count = pcr_pkg::CNT_W'(palette_fill);
        return res;
    endfunction

    task automatic queue_cmd(pcr_pkg::op_t op, logic [pcr_pkg::COLOR_W-1:0] c,
                             logic [pcr_pkg::ADDR_W-1:0] slot);
        palette_cmd_t cmd;
        cmd.op = op;
        cmd.color = c;
        cmd.slot = slot;
        command_backlog.push_back(cmd);
    endtask

    // driver: a word is taken at an edge with start high and busy low
    always @(posedge clk)
    begin
        palette_cmd_t taken;
        palette_cmd_t next_cmd;
        int unsigned  idle_pct;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!(start && busy))
        begin
            if (start)
            begin
                taken.op = pcr_pkg::op_t'(func);
                taken.color = color;
                taken.slot = index;
                expected_results.push_back(palette_apply(taken));
            end
            if (issued_count < PHASE_ITEMS)
                idle_pct = 29;
            else if (issued_count < 2 * PHASE_ITEMS)
                idle_pct = 74;
            else
                idle_pct = 0;
            if (command_backlog.size() != 0 && $urandom_range(0, 99) >= idle_pct)
            begin
                next_cmd = command_backlog.pop_front();
                func  <= next_cmd.op;
                color <= next_cmd.color;
                index <= next_cmd.slot;
                start <= 1'b1;
                issued_count++;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // monitor: done marks a result word for exactly one cycle
    always @(posedge clk)
    begin
        palette_result_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result word with nothing pending");
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (result_index !== want.slot)
                begin
                    $error("result_index: expected %0d, got %0d", want.slot, result_index);
                    mismatch_count++;
                end
                if (found !== want.hit)
                begin
                    $error("found: expected %0d, got %0d", want.hit, found);
                    mismatch_count++;
                end
                if (color_out !== want.shade)
                begin
                    $error("color_out: expected 0x%04h, got 0x%04h", want.shade, color_out);
                    mismatch_count++;
                end
                if (accepted !== want.wrote)
                begin
                    $error("accepted: expected %0d, got %0d", want.wrote, accepted);
                    mismatch_count++;
                end
                if (entry_count !== want.count)
                begin
                    $error("entry_count: expected %0d, got %0d", want.count, entry_count);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        palette_cmd_t cmd;
        int unsigned  pick;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // empty table: read, find and replace all fall through
        queue_cmd(pcr_pkg::OP_READ, 16'h0000, 8'd0);
        queue_cmd(pcr_pkg::OP_FIND, 16'h0000, 8'd0);
        queue_cmd(pcr_pkg::OP_REPLACE, 16'h1111, 8'd208);
        queue_cmd(pcr_pkg::OP_READ, 16'hFFFF, 8'd255);
        queue_cmd(pcr_pkg::OP_REGISTER, 16'h0000, 8'd0);
        queue_cmd(pcr_pkg::OP_REGISTER, 16'hFFFF, 8'd255);
        queue_cmd(pcr_pkg::OP_REGISTER, 16'h0000, 8'd17);
        queue_cmd(pcr_pkg::OP_REGISTER, 16'hFFFF, 8'd0);
        queue_cmd(pcr_pkg::OP_FIND, 16'h0000, 8'd255);
        queue_cmd(pcr_pkg::OP_FIND, 16'hFFFF, 8'd0);
        queue_cmd(pcr_pkg::OP_FIND, 16'h1234, 8'd0);
        queue_cmd(pcr_pkg::OP_READ, 16'h0000, 8'd0);
        queue_cmd(pcr_pkg::OP_READ, 16'h0000, 8'd1);
        queue_cmd(pcr_pkg::OP_READ, 16'h0000, 8'd2);
        queue_cmd(pcr_pkg::OP_REPLACE, 16'hBEEF, 8'd1);
        queue_cmd(pcr_pkg::OP_REPLACE, 16'hBEEF, 8'd209);
        queue_cmd(pcr_pkg::OP_REGISTER, 16'hA5A5, 8'hAA);
        queue_cmd(pcr_pkg::OP_REGISTER, 16'h5A5A, 8'h55);
        queue_cmd(pcr_pkg::OP_FIND, 16'h5A5A, 8'd3);
        queue_cmd(pcr_pkg::OP_READ, 16'h0000, 8'd3);
        queue_cmd(pcr_pkg::OP_REGISTER, 16'h8001, 8'hFF);
        queue_cmd(pcr_pkg::OP_FIND, 16'hA5A5, 8'd0);

        // random words, generated a couple ahead so they see the filled table
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            while (command_backlog.size() > 1)
                @(negedge clk);
            pick = $urandom_range(0, 99);
            cmd.color = pcr_pkg::COLOR_W'($urandom_range(0, 65535));
            cmd.slot = pcr_pkg::ADDR_W'($urandom_range(0, 255));
            if (pick < 40)
            begin
                cmd.op = pcr_pkg::OP_REGISTER;
                if (palette_fill > 0 && $urandom_range(0, 99) < 15)
                    cmd.color = palette_mem[
                        pcr_pkg::ADDR_W'($urandom_range(0, palette_fill - 1))];
            end
            else if (pick < 60)
            begin
                cmd.op = pcr_pkg::OP_FIND;
                if (palette_fill > 0 && $urandom_range(0, 99) < 60)
                    cmd.color = palette_mem[
                        pcr_pkg::ADDR_W'($urandom_range(0, palette_fill - 1))];
            end
            else if (pick < 80)
            begin
                cmd.op = pcr_pkg::OP_REPLACE;
                pick = $urandom_range(0, 99);
                if (pick < 30)
                    cmd.slot = pcr_pkg::ADDR_W'(pcr_pkg::RESERVED_BASE);
                else if (pick < 70)
                    cmd.slot = pcr_pkg::ADDR_W'($urandom_range(200, 255));
                pick = $urandom_range(0, 99);
                if (pick < 20 && cmd.slot < palette_fill)
                    cmd.color = palette_mem[cmd.slot];
                else if (pick < 55 && palette_fill > 0)
                    cmd.color = palette_mem[
                        pcr_pkg::ADDR_W'($urandom_range(0, palette_fill - 1))];
            end
            else
            begin
                cmd.op = pcr_pkg::OP_READ;
                if (palette_fill > 0 && $urandom_range(0, 99) < 60)
                    cmd.slot = pcr_pkg::ADDR_W'($urandom_range(0, palette_fill - 1));
            end
            command_backlog.push_back(cmd);
        end

        while (command_backlog.size() != 0 || start)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("[palette_color_registry] OK");
        else
            $display("[palette_color_registry] ERROR");
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial
    begin
        #(8 * 2500000);
        $display("[palette_color_registry] ERROR");
        $finish;
    end

endmodule

// ===== palette_color_registry.f =====
src/pcr_pkg.sv
src/pcr_ctrl.sv
src/pcr_dpath.sv
src/palette_color_registry.sv
src/pcr_checker.sv
dv/tb_palette_color_registry.sv
